@@ rtl/kpd_pkg.sv @@
// Shared types and constants for the keypad debounce and auto-repeat block.
// No dependencies.
package kpd_pkg;

  localparam int DEF_ROW_COUNT = 4;
  localparam int DEF_COL_COUNT = 4;

  localparam int BITS_W = 16;
  localparam int TIME_W = 32;
  localparam int CODE_W = 5;
  localparam int CFG_W  = 16;
  localparam int IDX_W  = 2;

  localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd20;
  localparam logic [CFG_W-1:0] DELAY_RST    = 16'd500;
  localparam logic [CFG_W-1:0] PERIOD_RST   = 16'd100;

  typedef enum logic [IDX_W-1:0] {
    REG_DEBOUNCE = 2'd0,
    REG_DELAY    = 2'd1,
    REG_PERIOD   = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [CFG_W-1:0] debounce_time;
    logic [CFG_W-1:0] repeat_delay;
    logic [CFG_W-1:0] repeat_period;
  } cfg_t;

endpackage

@@ rtl/kpd_decode.sv @@
// Snapshot decoder: turns the pressed bits into a single-key position code.
// Uses kpd_pkg for widths. Several keys down decode as no key.
module kpd_decode #(
  parameter int ROW_COUNT = kpd_pkg::DEF_ROW_COUNT,
  parameter int COL_COUNT = kpd_pkg::DEF_COL_COUNT
) (
  input  logic [kpd_pkg::BITS_W-1:0] pressed_bits,
  output logic [kpd_pkg::CODE_W-1:0] code
);

  localparam int KEYS      = ROW_COUNT * COL_COUNT;
  localparam int KEY_SLOTS = (KEYS < kpd_pkg::BITS_W) ? KEYS : kpd_pkg::BITS_W;

  logic [kpd_pkg::BITS_W-1:0] masked;
  logic [kpd_pkg::CODE_W-1:0] pos;
  logic                       single;

  always_comb begin
    for (int i = 0; i < kpd_pkg::BITS_W; i++) begin
      masked[i] = (i < KEY_SLOTS) ? pressed_bits[i] : 1'b0;
    end
  end

  // exactly one bit set
  assign single = (masked != '0) && ((masked & (masked - 1'b1)) == '0);

  // OR of the position codes (index plus one) is the code when only one bit is set
  always_comb begin
    pos = '0;
    for (int i = 0; i < kpd_pkg::BITS_W; i++) begin
      if (masked[i]) begin
        pos = pos | kpd_pkg::CODE_W'(i + 1);
      end
    end
  end

  assign code = single ? pos : '0;

endmodule

@@ rtl/kpd_core.sv @@
// Debounce and auto-repeat state with its decision logic and result register.
// Uses kpd_pkg for widths and the configuration struct.
module kpd_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       step,
  input  logic [kpd_pkg::CODE_W-1:0] code,
  input  logic [kpd_pkg::TIME_W-1:0] now_ms,
  input  kpd_pkg::cfg_t              cfg,
  output logic [kpd_pkg::CODE_W-1:0] key_event
);

  logic [kpd_pkg::CODE_W-1:0] candidate_code, candidate_code_next;
  logic [kpd_pkg::TIME_W-1:0] candidate_start, candidate_start_next;
  logic [kpd_pkg::CODE_W-1:0] stable_code, stable_code_next;
  logic [kpd_pkg::TIME_W-1:0] last_repeat_at, last_repeat_at_next;
  logic                       in_repeat, in_repeat_next;
  logic [kpd_pkg::CODE_W-1:0] event_next;
  logic [kpd_pkg::TIME_W-1:0] held, since_repeat;

  assign held         = now_ms - candidate_start;
  assign since_repeat = now_ms - last_repeat_at;

  always_comb begin
    candidate_code_next  = candidate_code;
    candidate_start_next = candidate_start;
    stable_code_next     = stable_code;
    last_repeat_at_next  = last_repeat_at;
    in_repeat_next       = in_repeat;
    event_next           = '0;
    priority if (code != candidate_code) begin
      candidate_code_next  = code;
      candidate_start_next = now_ms;
      in_repeat_next       = 1'b0;
    end else if (held < kpd_pkg::TIME_W'(cfg.debounce_time)) begin
      event_next = '0;
    end else if (code == '0) begin
      stable_code_next = '0;
      in_repeat_next   = 1'b0;
    end else if (code != stable_code) begin
      // new accepted key: press event
      stable_code_next    = code;
      last_repeat_at_next = now_ms;
      in_repeat_next      = 1'b0;
      event_next          = code;
    end else if (!in_repeat) begin
      if (held >= kpd_pkg::TIME_W'(cfg.repeat_delay)) begin
        in_repeat_next      = 1'b1;
        last_repeat_at_next = now_ms;
        event_next          = code;
      end
    end else if (since_repeat >= kpd_pkg::TIME_W'(cfg.repeat_period)) begin
      last_repeat_at_next = now_ms;
      event_next          = code;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      candidate_code  <= '0;
      candidate_start <= '0;
      stable_code     <= '0;
      last_repeat_at  <= '0;
      in_repeat       <= 1'b0;
    end else if (step) begin
      candidate_code  <= candidate_code_next;
      candidate_start <= candidate_start_next;
      stable_code     <= stable_code_next;
      last_repeat_at  <= last_repeat_at_next;
      in_repeat       <= in_repeat_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      key_event <= event_next;
    end
  end

  a_repeat_on_stable: assert property (@(posedge clk) disable iff (rst)
    in_repeat |-> (stable_code != '0 && candidate_code == stable_code))
    else $error("repeating without a held stable key");

  a_event_is_stable: assert property (@(posedge clk) disable iff (rst)
    step |=> (key_event == '0 || key_event == stable_code))
    else $error("event does not match the stable key");

  a_idle_holds: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(stable_code) && $stable(candidate_code))
    else $error("key state moved without a word");

endmodule

@@ rtl/keypad_debounce_autorepeat.sv @@
// Keypad debounce and auto-repeat: top level with stream ports and config port.
// Uses kpd_pkg, kpd_decode and kpd_core.
// An accepted input word passes the input register, then the decision logic into
// the result register, which drives m_axis_tvalid. Throughput: 1 word per
// cycle; the input stalls only while a result waits on m_axis_tready with the
// input register full.
// Reset (rst, synchronous) clears key state, handshake state and loads
// default registers: debounce 20 ms, repeat delay 500 ms, repeat period 100 ms.
module keypad_debounce_autorepeat #(
  parameter int ROW_COUNT = kpd_pkg::DEF_ROW_COUNT,
  parameter int COL_COUNT = kpd_pkg::DEF_COL_COUNT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [47:0]                 s_axis_tdata,  // pressed_bits[15:0], now_ms[47:16]
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [7:0]                  m_axis_tdata,  // key_event[4:0], zero pad[7:5]
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [kpd_pkg::IDX_W-1:0]   cfg_index,
  input  logic [kpd_pkg::CFG_W-1:0]   cfg_data
);

  kpd_pkg::cfg_t              cfg;
  logic [kpd_pkg::CODE_W-1:0] in_code, s1_code, key_event;
  logic [kpd_pkg::TIME_W-1:0] s1_now;
  logic                       s1_valid, out_valid;
  logic                       out_free, step;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_time <= kpd_pkg::DEBOUNCE_RST;
      cfg.repeat_delay  <= kpd_pkg::DELAY_RST;
      cfg.repeat_period <= kpd_pkg::PERIOD_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        kpd_pkg::REG_DEBOUNCE: cfg.debounce_time <= cfg_data;
        kpd_pkg::REG_DELAY:    cfg.repeat_delay  <= cfg_data;
        kpd_pkg::REG_PERIOD:   cfg.repeat_period <= cfg_data;
        default:               cfg               <= cfg;
      endcase
    end
  end

  kpd_decode #(
    .ROW_COUNT (ROW_COUNT),
    .COL_COUNT (COL_COUNT)
  ) u_decode (
    .pressed_bits (s_axis_tdata[15:0]),
    .code         (in_code)
  );

  assign out_free      = !out_valid || m_axis_tready;
  assign step          = s1_valid && out_free;
  assign s_axis_tready = !s1_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        s1_valid <= s_axis_tvalid;
      end
      if (out_free) begin
        out_valid <= s1_valid;
      end
    end
  end

  // hold the decoded word until the decision stage takes it
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s1_code <= in_code;
      s1_now  <= s_axis_tdata[47:16];
    end
  end

  kpd_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .code      (s1_code),
    .now_ms    (s1_now),
    .cfg       (cfg),
    .key_event (key_event)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {3'b000, key_event};

endmodule

@@ test/keypad_debounce_autorepeat_tb.sv @@
// Testbench for keypad_debounce_autorepeat: directed and random key snapshots,
// checked word by word against a scoreboard that predicts every key event.
// Depends on kpd_pkg and the keypad_debounce_autorepeat RTL.
`timescale 1ns / 100ps

module keypad_debounce_autorepeat_tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam int KEY_SLOTS = 16;
  localparam int HOLD_OFF_CYCLES = 300;
  // index 3 maps to no register and must be ignored
  localparam logic [kpd_pkg::IDX_W-1:0] REG_UNUSED = 2'd3;

  class key_event_board;
    logic [kpd_pkg::CFG_W-1:0]  debounce;
    logic [kpd_pkg::CFG_W-1:0]  delay;
    logic [kpd_pkg::CFG_W-1:0]  period;
    logic [kpd_pkg::CODE_W-1:0] cand_code;
    logic [kpd_pkg::TIME_W-1:0] cand_start;
    logic [kpd_pkg::CODE_W-1:0] stable_code;
    logic [kpd_pkg::TIME_W-1:0] last_repeat;
    logic                       repeating;
    logic [kpd_pkg::CODE_W-1:0] pending_events[$];
    int                         errors;

    function new();
      debounce    = kpd_pkg::DEBOUNCE_RST;
      delay       = kpd_pkg::DELAY_RST;
      period      = kpd_pkg::PERIOD_RST;
      cand_code   = '0;
      cand_start  = '0;
      stable_code = '0;
      last_repeat = '0;
      repeating   = 1'b0;
      errors      = 0;
    endfunction

    function void set_reg(logic [kpd_pkg::IDX_W-1:0] idx, logic [kpd_pkg::CFG_W-1:0] val);
      case (idx)
        kpd_pkg::REG_DEBOUNCE: debounce = val;
        kpd_pkg::REG_DELAY:    delay = val;
        kpd_pkg::REG_PERIOD:   period = val;
        default: ;
      endcase
    endfunction

    // position code of the one pressed key; none or several give 0
    function logic [kpd_pkg::CODE_W-1:0] single_key(logic [kpd_pkg::BITS_W-1:0] bits);
      logic [kpd_pkg::CODE_W-1:0] found;
      found = '0;
      for (int i = 0; i < KEY_SLOTS; i++) begin
        if (bits[i]) begin
          if (found != 0) return '0;
          found = kpd_pkg::CODE_W'(i + 1);
        end
      end
      return found;
    endfunction

    function logic [kpd_pkg::CODE_W-1:0] predict_event(logic [kpd_pkg::BITS_W-1:0] bits,
                                                       logic [kpd_pkg::TIME_W-1:0] now);
      logic [kpd_pkg::CODE_W-1:0] cur;
      logic [kpd_pkg::TIME_W-1:0] held;
      cur = single_key(bits);
      if (cur != cand_code) begin
        cand_code  = cur;
        cand_start = now;
        repeating  = 1'b0;
        return '0;
      end
      held = now - cand_start;
      if (held < {16'h0, debounce}) return '0;
      if (cur == 0) begin
        if (stable_code != 0) begin
          stable_code = '0;
          repeating   = 1'b0;
        end
        return '0;
      end
      if (cur != stable_code) begin
        stable_code = cur;
        last_repeat = now;
        repeating   = 1'b0;
        return cur;
      end
      if (!repeating) begin
        if (held >= {16'h0, delay}) begin
          repeating   = 1'b1;
          last_repeat = now;
          return cur;
        end
      end else if (kpd_pkg::TIME_W'(now - last_repeat) >= {16'h0, period}) begin
        last_repeat = now;
        return cur;
      end
      return '0;
    endfunction

    function void note_word(logic [kpd_pkg::BITS_W-1:0] bits,
                            logic [kpd_pkg::TIME_W-1:0] now);
      pending_events.push_back(predict_event(bits, now));
    endfunction

    function void check_word(logic [kpd_pkg::CODE_W-1:0] got);
      logic [kpd_pkg::CODE_W-1:0] want;
      if (pending_events.size() == 0) begin
        errors++;
        if (errors <= 20)
          $display("%0t: unexpected key_event %0d, nothing pending", $time, got);
        return;
      end
      want = pending_events.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 20)
          $display("%0t: key_event mismatch, expected %0d actual %0d", $time, want, got);
      end
    endfunction
  endclass

  logic                       clk;
  logic                       rst;
  logic                       s_axis_tvalid;
  logic                       s_axis_tready;
  logic [47:0]                s_axis_tdata;   // pressed_bits[15:0], now_ms[47:16]
  logic                       m_axis_tvalid;
  logic                       m_axis_tready;
  logic [7:0]                 m_axis_tdata;   // key_event[4:0], zero pad[7:5]
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [kpd_pkg::IDX_W-1:0]  cfg_index;
  logic [kpd_pkg::CFG_W-1:0]  cfg_data;

  key_event_board             sb;
  int                         src_idle;
  int                         snk_stall;
  bit                         hold_req;
  int                         hold_left;
  int                         cycles;
  logic [kpd_pkg::TIME_W-1:0] ms_now;

  keypad_debounce_autorepeat u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_OFF_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= snk_stall);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_word(m_axis_tdata[kpd_pkg::CODE_W-1:0]);
  end

  task automatic send_word(input logic [kpd_pkg::BITS_W-1:0] bits,
                           input logic [kpd_pkg::TIME_W-1:0] now);
    @(negedge clk);
    while ($urandom_range(99) < src_idle) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {now, bits};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_word(bits, now);
  endtask

  task automatic write_reg(input logic [kpd_pkg::IDX_W-1:0] idx,
                           input logic [kpd_pkg::CFG_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // drop valid, wait for every pending event, then let the pipeline settle
  task automatic drain();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (sb.pending_events.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(input logic [kpd_pkg::CFG_W-1:0] dt,
                            input logic [kpd_pkg::CFG_W-1:0] dl,
                            input logic [kpd_pkg::CFG_W-1:0] pd);
    drain();
    write_reg(kpd_pkg::REG_DEBOUNCE, dt);
    write_reg(kpd_pkg::REG_DELAY, dl);
    write_reg(kpd_pkg::REG_PERIOD, pd);
  endtask

  // mostly clean key holds with random timing, some releases, ghosts and noise, and jumps near the timestamp wrap
  task automatic run_random(input int n);
    int                         sent;
    int                         r;
    int                         len;
    int                         step_max;
    int                         a;
    int                         b;
    logic [kpd_pkg::BITS_W-1:0] key;
    logic [kpd_pkg::BITS_W-1:0] bits;
    sent = 0;
    step_max = (int'(sb.debounce) + int'(sb.delay) + int'(sb.period)) / 16 + 1;
    while (sent < n) begin
      r = $urandom_range(99);
      if (r < 72) begin
        key = 16'h1 << $urandom_range(15);
        len = $urandom_range(40, 1);
        for (int k = 0; k < len; k++) begin
          bits = key;
          // occasional contact bounce
          if ($urandom_range(19) == 0) bits = 16'($urandom);
          ms_now += kpd_pkg::TIME_W'($urandom_range(step_max));
          send_word(bits, ms_now);
        end
        sent += len;
      end else if (r < 90) begin
        len = $urandom_range(10, 1);
        for (int k = 0; k < len; k++) begin
          if ($urandom_range(1) == 0) begin
            bits = '0;
          end else begin
            a = $urandom_range(15);
            b = (a + 1 + $urandom_range(14)) % 16;
            bits = (16'h1 << a) | (16'h1 << b) | 16'($urandom);
          end
          ms_now += kpd_pkg::TIME_W'($urandom_range(step_max));
          send_word(bits, ms_now);
        end
        sent += len;
      end else if (r < 96) begin
        len = $urandom_range(3, 1);
        for (int k = 0; k < len; k++) begin
          ms_now = $urandom;
          send_word(16'($urandom), ms_now);
        end
        sent += len;
      end else begin
        // jump close to the timestamp wrap
        ms_now = 32'hFFFF_FFFF - kpd_pkg::TIME_W'($urandom_range(step_max * 4));
      end
    end
  endtask

  initial begin
    sb            = new();
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = kpd_pkg::REG_DEBOUNCE;
    cfg_data      = '0;
    src_idle      = 0;
    snk_stall     = 0;
    hold_req      = 1'b0;
    hold_left     = 0;
    cycles        = 0;
    ms_now        = 32'd2000;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: press, first repeat, later repeats
    send_word(16'h0001, 32'd1000);
    send_word(16'h0001, 32'd1010);
    send_word(16'h0001, 32'd1020);
    send_word(16'h0001, 32'd1300);
    send_word(16'h0001, 32'd1520);
    send_word(16'h0001, 32'd1600);
    send_word(16'h0001, 32'd1620);
    // ghost: two keys count as none, then release
    send_word(16'h0003, 32'd1630);
    send_word(16'h0003, 32'd1700);
    send_word(16'h8000, 32'd1710);
    send_word(16'h8000, 32'd1730);
    send_word(16'hFFFF, 32'd1740);
    send_word(16'h0000, 32'd1800);
    // timestamp going backwards
    send_word(16'h0400, 32'd5000);
    send_word(16'h0400, 32'd4000);
    send_word(16'h0400, 32'd4001);
    // across the wrap
    send_word(16'h0020, 32'hFFFF_FFF0);
    send_word(16'h0020, 32'h0000_0010);
    send_word(16'h0000, 32'h0000_0020);

    src_idle = 0;
    snk_stall = 0;
    run_random(130);

    // zero debounce, delay and period: every held step emits
    set_config(16'd0, 16'd0, 16'd0);
    send_word(16'h0002, 32'd100);
    send_word(16'h0002, 32'd100);
    send_word(16'h0002, 32'd100);
    send_word(16'h0002, 32'd100);
    send_word(16'h0004, 32'd100);
    snk_stall = 76;
    run_random(115);

    set_config(16'd5, 16'd40, 16'd10);
    snk_stall = 0;
    src_idle = 76;
    run_random(150);

    set_config(16'hFFFF, 16'hFFFF, 16'hFFFF);
    src_idle = 37;
    snk_stall = 37;
    run_random(100);

    set_config(16'd3, 16'd20, 16'd0);
    run_random(100);

    // back-pressure: long receiver hold-off with the sender always offering
    set_config(16'd10, 16'd50, 16'd5);
    src_idle = 0;
    snk_stall = 0;
    run_random(40);
    hold_req = 1'b1;
    run_random(40);

    drain();
    write_reg(REG_UNUSED, 16'h1234);
    set_config(16'd0, 16'hFFFF, 16'd1);
    snk_stall = 76;
    run_random(150);

    drain();
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
